### hw/rtl/ntcb_pkg.sv
`timescale 1ns / 1ps
package ntcb_pkg;

  // default converter width
  localparam int ADC_BITS_DEF = 12;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int OHM_W      = 24;
  localparam int BETA_W     = 16;
  localparam int TK_W       = 16;

  // result fields
  localparam int STATUS_W = 3;
  localparam int RES_W    = 32;
  localparam int TEMP_W   = 16;

  // log2 datapath: q30 mantissa, 28 fraction bits
  localparam int MANT_W    = 31;
  localparam int FRAC_BITS = 28;

  // temperature datapath widths
  localparam int B100_W = 23;
  localparam int BT_W   = 39;
  localparam int D_W    = 50;
  localparam int TDVD_W = 64;
  localparam int TDVS_W = 48;
  localparam int TQ_W   = 16;
  localparam int RQ_W   = 32;
  localparam int SPLIT  = 17;

  localparam logic [27:0] LN2_Q28 = 28'd186065280;
  localparam logic [6:0]  CENTI   = 7'd100;
  localparam logic [16:0] ZERO_C_CENTIK = 17'd27315;
  // first centikelvin value that no longer fits the signed result
  localparam logic [15:0] SAT_FACTOR = 16'd60083;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX      = 16'sd32767;
  localparam logic signed [TEMP_W-1:0] TEMP_ABS_ZERO = -16'sd27315;

  // reset values
  localparam int FS_RST = 4095;
  localparam logic [OHM_W-1:0]  REF_RST  = 24'd10000;
  localparam logic [OHM_W-1:0]  NOM_RST  = 24'd10000;
  localparam logic [BETA_W-1:0] BETA_RST = 16'd3950;
  localparam logic [TK_W-1:0]   T25_RST  = 16'd29815;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_SCALE = 3'd0,
    REG_REF_OHMS   = 3'd1,
    REG_NOM_OHMS   = 3'd2,
    REG_BETA       = 3'd3,
    REG_NOM_CK     = 3'd4
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL_SCALE = 3'd1,
    ST_ZERO       = 3'd2,
    ST_BAD_CFG    = 3'd3,
    ST_TEMP_SAT   = 3'd4
  } status_t;

  typedef struct packed {
    logic             at_fs;
    logic             zero;
    logic [RES_W-1:0] res;
  } info_t;

endpackage

### hw/rtl/ntcb_div.sv
`timescale 1ns / 1ps
module ntcb_div #(
  parameter int NW = 37,
  parameter int DW = 13,
  parameter int QW = 32,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_dvd,
  input  logic [DW-1:0] in_dvs,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [TW-1:0] out_tag
);

  // restoring division, one quotient bit per stage, msb first;
  // quotient is exact when the dividend is below divisor << QW
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic          v_r   [QW];
  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] dvs_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [TW-1:0] tag_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] dvs_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] tag_in;
    logic [CW-1:0] sub_w;
    logic          ge;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = in_dvd;
      assign dvs_in = in_dvs;
      assign quo_in = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign rem_in = rem_r[k-1];
      assign dvs_in = dvs_r[k-1];
      assign quo_in = quo_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    assign sub_w   = CW'(dvs_in) << (QW - 1 - k);
    assign ge      = CW'(rem_in) >= sub_w;
    assign rem_nxt = ge ? NW'(CW'(rem_in) - sub_w) : rem_in;
    assign quo_nxt = quo_in | (ge ? (QW'(1) << (QW - 1 - k)) : '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        dvs_r[k] <= dvs_in;
        quo_r[k] <= quo_nxt;
        tag_r[k] <= tag_in;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_tag   = tag_r[QW-1];

endmodule

### hw/rtl/ntcb_log2.sv
`timescale 1ns / 1ps
module ntcb_log2 #(
  parameter int XW = 36,
  parameter int TW = 1
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  logic                                      in_valid,
  input  logic [XW-1:0]                             in_x_a,
  input  logic [XW-1:0]                             in_x_b,
  input  logic [TW-1:0]                             in_tag,
  output logic                                      out_valid,
  output logic [$clog2(XW)+ntcb_pkg::FRAC_BITS-1:0] out_log_a,
  output logic [$clog2(XW)+ntcb_pkg::FRAC_BITS-1:0] out_log_b,
  output logic [TW-1:0]                             out_tag
);
  import ntcb_pkg::*;

  localparam int EW = $clog2(XW);
  localparam int SH = MANT_W - 1;
  localparam int LAST = FRAC_BITS - 1;

  function automatic logic [EW-1:0] msb_pos(input logic [XW-1:0] x);
    logic [EW-1:0] p;
    p = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) p = EW'(i);
    end
    return p;
  endfunction

  logic [XW-1:0] x_in [2];
  assign x_in[0] = in_x_a;
  assign x_in[1] = in_x_b;

  // stage 0: exponent, stage 1: normalised mantissa
  logic             v0_r;
  logic             v1_r;
  logic [TW-1:0]    tag0_r;
  logic [TW-1:0]    tag1_r;
  logic [XW-1:0]    x0_r  [2];
  logic [EW-1:0]    e0_r  [2];
  logic [EW-1:0]    e1_r  [2];
  logic [MANT_W-1:0] m1_r  [2];
  logic [XW+SH-1:0]  sh_w  [2];
  logic [MANT_W-1:0] m1_nxt [2];

  // squaring stages, one fraction bit each
  logic              vi_r   [FRAC_BITS];
  logic [TW-1:0]     tagi_r [FRAC_BITS];
  logic [MANT_W-1:0] mi_r   [FRAC_BITS][2];
  logic [FRAC_BITS-1:0] fi_r [FRAC_BITS][2];
  logic [EW-1:0]     ei_r   [FRAC_BITS][2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sh_w[l]   = {x0_r[l], {SH{1'b0}}} >> e0_r[l];
      m1_nxt[l] = sh_w[l][MANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag0_r <= in_tag;
      tag1_r <= tag0_r;
      for (int l = 0; l < 2; l++) begin
        x0_r[l] <= x_in[l];
        e0_r[l] <= msb_pos(x_in[l]);
        m1_r[l] <= m1_nxt[l];
        e1_r[l] <= e0_r[l];
      end
    end
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_iter
    logic          v_src;
    logic [TW-1:0] tag_src;

    if (j == 0) begin : g_first
      assign v_src   = v1_r;
      assign tag_src = tag1_r;
    end else begin : g_next
      assign v_src   = vi_r[j-1];
      assign tag_src = tagi_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vi_r[j] <= 1'b0;
      end else if (en) begin
        vi_r[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) tagi_r[j] <= tag_src;
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [MANT_W-1:0]    m_src;
      logic [FRAC_BITS-1:0] f_src;
      logic [EW-1:0]        e_src;
      logic [2*MANT_W-1:0]  sq;
      logic [MANT_W:0]      t;
      logic [MANT_W-1:0]    m_nxt;
      logic [FRAC_BITS-1:0] f_nxt;

      if (j == 0) begin : g_first
        assign m_src = m1_r[l];
        assign f_src = '0;
        assign e_src = e1_r[l];
      end else begin : g_next
        assign m_src = mi_r[j-1][l];
        assign f_src = fi_r[j-1][l];
        assign e_src = ei_r[j-1][l];
      end

      // square stays in [1,4): a carry into bit 31 means one more fraction bit
      assign sq    = (2*MANT_W)'(m_src) * (2*MANT_W)'(m_src);
      assign t     = sq[2*MANT_W-1:SH];
      assign m_nxt = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
      assign f_nxt = {f_src[FRAC_BITS-2:0], t[MANT_W]};

      always_ff @(posedge clk) begin
        if (en) begin
          mi_r[j][l] <= m_nxt;
          fi_r[j][l] <= f_nxt;
          ei_r[j][l] <= e_src;
        end
      end
    end
  end

  assign out_valid = vi_r[LAST];
  assign out_tag   = tagi_r[LAST];
  assign out_log_a = {ei_r[LAST][0], fi_r[LAST][0]};
  assign out_log_b = {ei_r[LAST][1], fi_r[LAST][1]};

endmodule

### hw/rtl/ntc_beta_temperature_converter_core.sv
`timescale 1ns / 1ps
// ntc thermistor converter: adc count in, resistance and beta-equation temperature out
//
// config: cfg_we writes cfg_data into the register picked by cfg_index
//   (full scale count, reference ohms, nominal ohms, beta, nominal centikelvin);
//   write only while no item is in flight, unused indexes are ignored
// input channel: in_valid/in_ready carrying in_adc_sample
// result channel: out_valid/out_ready carrying out_status, out_resistance_ohms
//   and out_temperature_centi_c (signed, 0.01 degC)
// throughput: one item per cycle while no result waits on out_ready, fully pipelined
// pipeline: 89 register stages from the accepting edge to out_valid:
//   3 front-end stages, the 32-step resistance divider, 30 stages of log2
//   (28 squarings), 7 arithmetic stages, the 16-step temperature divider and
//   the output register
// stall: one enable moves the whole pipeline; while a result waits on
//   out_ready nothing moves and in_ready is low, so no item is lost or doubled
// reset: synchronous active-low rst_n empties the pipeline and loads the
//   configuration defaults (full scale 4095, 10k/10k ohms, beta 3950, 298.15 K)
module ntc_beta_temperature_converter_core #(
  parameter int ADC_BITS = ntcb_pkg::ADC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ntcb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ntcb_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ADC_BITS-1:0]                   in_adc_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ntcb_pkg::STATUS_W-1:0]         out_status,
  output logic [ntcb_pkg::RES_W-1:0]            out_resistance_ohms,
  output logic signed [ntcb_pkg::TEMP_W-1:0]    out_temperature_centi_c
);
  import ntcb_pkg::*;

  localparam int NUMW    = OHM_W + ADC_BITS;      // reference_ohms * count
  localparam int RDVD_W  = NUMW + 1;              // 2*num + den
  localparam int RDVS_W  = ADC_BITS + 1;          // 2*den
  localparam int LOG_W   = $clog2(NUMW) + FRAC_BITS;
  localparam int PROD_W  = LOG_W + 28;            // mag * ln2
  localparam int LMAG_W  = LOG_W - 3;
  localparam int LQ_W    = LMAG_W + 1;
  localparam int LT_W    = LQ_W + TK_W + 1;
  localparam int INFO_W  = $bits(info_t);
  localparam int TAG1_W  = 3 + 2 * NUMW;
  localparam int TAG2_W  = INFO_W + 2;
  localparam logic [ADC_BITS-1:0] FS_RST_V = ADC_BITS'(FS_RST);

  // ---------------------------------------------------------------- config
  logic [ADC_BITS-1:0] fs_r;
  logic [OHM_W-1:0]    ref_r;
  logic [OHM_W-1:0]    nom_r;
  logic [BETA_W-1:0]   beta_r;
  logic [TK_W-1:0]     t25_r;
  logic [B100_W-1:0]   b100_r;
  logic [BT_W-1:0]     bt_r;
  logic                bad_cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r   <= FS_RST_V;
      ref_r  <= REF_RST;
      nom_r  <= NOM_RST;
      beta_r <= BETA_RST;
      t25_r  <= T25_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FULL_SCALE: fs_r   <= cfg_data[ADC_BITS-1:0];
        REG_REF_OHMS:   ref_r  <= cfg_data[OHM_W-1:0];
        REG_NOM_OHMS:   nom_r  <= cfg_data[OHM_W-1:0];
        REG_BETA:       beta_r <= cfg_data[BETA_W-1:0];
        REG_NOM_CK:     t25_r  <= cfg_data[TK_W-1:0];
        default: ;
      endcase
    end
  end

  // constants derived from config, settle long before an item gets there
  always_ff @(posedge clk) begin
    b100_r <= B100_W'(beta_r) * B100_W'(CENTI);
    bt_r   <= BT_W'(b100_r) * BT_W'(t25_r);
  end

  assign bad_cfg = (nom_r == '0) || (beta_r == '0) || (ref_r == '0) || (t25_r == '0);

  // ---------------------------------------------------------------- flow
  logic out_valid_r;
  logic adv;

  // single pipeline enable: moves whenever the output slot is free or being taken
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // stage a: sample capture
  logic                a_v_r;
  logic [ADC_BITS-1:0] a_cnt_r;

  // stage b: range flags, denominator and the two products
  logic                b_v_r;
  logic                b_at_fs_r;
  logic                b_zero_r;
  logic [ADC_BITS-1:0] b_den_r;
  logic [NUMW-1:0]     b_num_r;
  logic [NUMW-1:0]     b_dprod_r;
  logic [ADC_BITS-1:0] den_nxt;

  // stage c: rounding dividend and resistance overflow check
  logic                c_v_r;
  logic                c_at_fs_r;
  logic                c_zero_r;
  logic                c_rsat_r;
  logic [RDVD_W-1:0]   c_rdvd_r;
  logic [RDVS_W-1:0]   c_rdvs_r;
  logic [NUMW-1:0]     c_num_r;
  logic [NUMW-1:0]     c_dprod_r;
  logic [RDVD_W-1:0]   rdvd_nxt;
  logic [RDVS_W-1:0]   rdvs_nxt;

  assign den_nxt  = fs_r - a_cnt_r;
  assign rdvd_nxt = RDVD_W'({b_num_r, 1'b0}) + RDVD_W'(b_den_r);
  assign rdvs_nxt = {b_den_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cnt_r   <= in_adc_sample;
      b_at_fs_r <= a_cnt_r >= fs_r;
      b_zero_r  <= a_cnt_r == '0;
      b_den_r   <= den_nxt;
      b_num_r   <= NUMW'(ref_r) * NUMW'(a_cnt_r);
      b_dprod_r <= NUMW'(nom_r) * NUMW'(den_nxt);
      c_at_fs_r <= b_at_fs_r;
      c_zero_r  <= b_zero_r;
      // quotient reaches 2^32 exactly when dividend / 2^32 >= divisor
      c_rsat_r  <= RDVS_W'(rdvd_nxt[RDVD_W-1:32]) >= rdvs_nxt;
      c_rdvd_r  <= rdvd_nxt;
      c_rdvs_r  <= rdvs_nxt;
      c_num_r   <= b_num_r;
      c_dprod_r <= b_dprod_r;
    end
  end

  // ---------------------------------------------------------------- resistance
  logic              d1_v;
  logic [RQ_W-1:0]   d1_q;
  logic [TAG1_W-1:0] d1_tag;
  logic              d1_at_fs;
  logic              d1_zero;
  logic              d1_rsat;
  logic [NUMW-1:0]   d1_num;
  logic [NUMW-1:0]   d1_dprod;
  info_t             d1_info;

  ntcb_div #(
    .NW (RDVD_W),
    .DW (RDVS_W),
    .QW (RQ_W),
    .TW (TAG1_W)
  ) u_res_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (c_v_r),
    .in_dvd    (c_rdvd_r),
    .in_dvs    (c_rdvs_r),
    .in_tag    ({c_at_fs_r, c_zero_r, c_rsat_r, c_num_r, c_dprod_r}),
    .out_valid (d1_v),
    .out_quo   (d1_q),
    .out_tag   (d1_tag)
  );

  assign {d1_at_fs, d1_zero, d1_rsat, d1_num, d1_dprod} = d1_tag;
  assign d1_info.at_fs = d1_at_fs;
  assign d1_info.zero  = d1_zero;
  assign d1_info.res   = d1_rsat ? '1 : d1_q;

  // ---------------------------------------------------------------- logs
  logic             lg_v;
  logic [LOG_W-1:0] lg_num;
  logic [LOG_W-1:0] lg_den;
  logic [INFO_W-1:0] lg_tag;

  // log2(reference_ohms*count) and log2(nominal_ohms*(fs-count)) side by side
  ntcb_log2 #(
    .XW (NUMW),
    .TW (INFO_W)
  ) u_log2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (d1_v),
    .in_x_a    (d1_num),
    .in_x_b    (d1_dprod),
    .in_tag    (d1_info),
    .out_valid (lg_v),
    .out_log_a (lg_num),
    .out_log_b (lg_den),
    .out_tag   (lg_tag)
  );

  // ---------------------------------------------------------------- temperature
  // t1: |log difference|
  logic               t1_v_r;
  info_t              t1_info_r;
  logic               t1_neg_r;
  logic [LOG_W-1:0]   t1_mag_r;
  logic               neg_nxt;

  // t2: ln2 scaling split into two partial products
  logic                    t2_v_r;
  info_t                   t2_info_r;
  logic                    t2_neg_r;
  logic [SPLIT+27:0]       t2_lo_r;
  logic [LOG_W-SPLIT+27:0] t2_hi_r;

  // t3: ln ratio in q24, rounded on the magnitude
  logic                    t3_v_r;
  info_t                   t3_info_r;
  logic signed [LQ_W-1:0]  t3_lq_r;
  logic [PROD_W-1:0]       prod_w;
  logic [PROD_W:0]         rnd_w;
  logic [LMAG_W-1:0]       lmag_w;

  // t4: ln ratio times nominal centikelvin
  logic                    t4_v_r;
  info_t                   t4_info_r;
  logic signed [LT_W-1:0]  t4_lt_r;

  // t5: denominator
  logic                    t5_v_r;
  info_t                   t5_info_r;
  logic signed [D_W-1:0]   t5_d_r;
  logic                    t5_dfail_r;
  logic signed [D_W-1:0]   d_nxt;

  // t6: rounded dividend and saturation product
  logic                    t6_v_r;
  info_t                   t6_info_r;
  logic                    t6_dfail_r;
  logic [TDVD_W-1:0]       t6_dvd_r;
  logic [TDVD_W-1:0]       t6_pm_r;
  logic [TDVS_W-1:0]       t6_dvs_r;
  logic [TDVS_W-1:0]       dvs_nxt;

  // t7: saturation decision
  logic                    t7_v_r;
  info_t                   t7_info_r;
  logic                    t7_dfail_r;
  logic                    t7_tsat_r;
  logic [TDVD_W-1:0]       t7_dvd_r;
  logic [TDVS_W-1:0]       t7_dvs_r;

  assign neg_nxt = lg_den > lg_num;
  assign prod_w  = (PROD_W'(t2_hi_r) << SPLIT) + PROD_W'(t2_lo_r);
  assign rnd_w   = {1'b0, prod_w} + (PROD_W+1)'(33'h0_8000_0000);
  assign lmag_w  = rnd_w[PROD_W:32];
  assign d_nxt   = $signed(D_W'({b100_r, 24'b0})) + D_W'(t4_lt_r);
  assign dvs_nxt = t5_d_r[TDVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
      t4_v_r <= 1'b0;
      t5_v_r <= 1'b0;
      t6_v_r <= 1'b0;
      t7_v_r <= 1'b0;
    end else if (adv) begin
      t1_v_r <= lg_v;
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
      t4_v_r <= t3_v_r;
      t5_v_r <= t4_v_r;
      t6_v_r <= t5_v_r;
      t7_v_r <= t6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_info_r  <= info_t'(lg_tag);
      t1_neg_r   <= neg_nxt;
      t1_mag_r   <= neg_nxt ? (lg_den - lg_num) : (lg_num - lg_den);

      t2_info_r  <= t1_info_r;
      t2_neg_r   <= t1_neg_r;
      t2_lo_r    <= (SPLIT+28)'(t1_mag_r[SPLIT-1:0]) * (SPLIT+28)'(LN2_Q28);
      t2_hi_r    <= (LOG_W-SPLIT+28)'(t1_mag_r[LOG_W-1:SPLIT]) * (LOG_W-SPLIT+28)'(LN2_Q28);

      t3_info_r  <= t2_info_r;
      t3_lq_r    <= t2_neg_r ? -$signed({1'b0, lmag_w}) : $signed({1'b0, lmag_w});

      t4_info_r  <= t3_info_r;
      t4_lt_r    <= LT_W'(t3_lq_r) * LT_W'($signed({1'b0, t25_r}));

      t5_info_r  <= t4_info_r;
      t5_d_r     <= d_nxt;
      t5_dfail_r <= d_nxt <= 0;

      t6_info_r  <= t5_info_r;
      t6_dfail_r <= t5_dfail_r;
      t6_dvd_r   <= TDVD_W'({bt_r, 24'b0}) + TDVD_W'(dvs_nxt >> 1);
      t6_pm_r    <= TDVD_W'(dvs_nxt) * TDVD_W'(SAT_FACTOR);
      t6_dvs_r   <= dvs_nxt;

      // quotient above the signed range exactly when dividend >= 60083*d
      t7_info_r  <= t6_info_r;
      t7_dfail_r <= t6_dfail_r;
      t7_tsat_r  <= t6_dvd_r >= t6_pm_r;
      t7_dvd_r   <= t6_dvd_r;
      t7_dvs_r   <= t6_dvs_r;
    end
  end

  logic              d2_v;
  logic [TQ_W-1:0]   d2_q;
  logic [TAG2_W-1:0] d2_tag;
  info_t             d2_info;
  logic              d2_dfail;
  logic              d2_tsat;

  // below saturation the centikelvin quotient fits 16 bits
  ntcb_div #(
    .NW (TDVD_W),
    .DW (TDVS_W),
    .QW (TQ_W),
    .TW (TAG2_W)
  ) u_temp_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (t7_v_r),
    .in_dvd    (t7_dvd_r),
    .in_dvs    (t7_dvs_r),
    .in_tag    ({t7_info_r, t7_dfail_r, t7_tsat_r}),
    .out_valid (d2_v),
    .out_quo   (d2_q),
    .out_tag   (d2_tag)
  );

  assign {d2_info, d2_dfail, d2_tsat} = d2_tag;

  // ---------------------------------------------------------------- result
  status_t                   status_r;
  status_t                   status_nxt;
  logic [RES_W-1:0]          res_r;
  logic [RES_W-1:0]          res_nxt;
  logic signed [TEMP_W-1:0]  temp_r;
  logic signed [TEMP_W-1:0]  temp_nxt;
  logic signed [TEMP_W:0]    tc_w;

  assign tc_w = $signed({1'b0, d2_q}) - $signed(ZERO_C_CENTIK);

  // special cases in priority order
  always_comb begin
    status_nxt = ST_OK;
    res_nxt    = d2_info.res;
    temp_nxt   = tc_w[TEMP_W-1:0];
    if (d2_info.at_fs) begin
      status_nxt = ST_FULL_SCALE;
      res_nxt    = '1;
      temp_nxt   = TEMP_ABS_ZERO;
    end else if (d2_info.zero) begin
      status_nxt = ST_ZERO;
      res_nxt    = '0;
      temp_nxt   = TEMP_ABS_ZERO;
    end else if (bad_cfg) begin
      status_nxt = ST_BAD_CFG;
      temp_nxt   = '0;
    end else if (d2_dfail || d2_tsat) begin
      status_nxt = ST_TEMP_SAT;
      temp_nxt   = TEMP_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      temp_r   <= temp_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = status_r;
  assign out_resistance_ohms     = res_r;
  assign out_temperature_centi_c = temp_r;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item accepted while result stalled");

  a_full_scale_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL_SCALE |->
      out_resistance_ohms == '1 && out_temperature_centi_c == TEMP_ABS_ZERO)
    else $error("full scale result fields wrong");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ZERO |->
      out_resistance_ohms == '0 && out_temperature_centi_c == TEMP_ABS_ZERO)
    else $error("zero count result fields wrong");

  a_bad_cfg_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BAD_CFG |-> out_temperature_centi_c == '0)
    else $error("bad config temperature not zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

### tb/sv/tb_ntc_beta_temperature_converter_core.sv
`timescale 1ns / 1ps
module tb_ntc_beta_temperature_converter_core;
  import ntcb_pkg::*;

  localparam int ADC_W      = ADC_BITS_DEF;
  localparam int PIPE_DEPTH = 88;
  localparam int DRAIN_WAIT = PIPE_DEPTH + 12;
  localparam int CYCLE_CAP  = 400000;
  localparam int RAND_ITEMS = 850;
  localparam int N_PHASES   = 8;
  localparam longint unsigned LN2_FIX = 64'd186065280;
  localparam longint ZERO_C  = 27315;

  // one converted item as the block should present it
  typedef struct {
    status_t          st;
    logic [RES_W-1:0] ohms;
    logic [TEMP_W-1:0] temp;
  } reading_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // directed stimulus: register write or sample, with an optional typed-in answer
  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  value;
    logic [ADC_W-1:0]       sample;
    bit                     typed;
    reading_t               answer;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ADC_W-1:0] in_adc_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [RES_W-1:0] out_resistance_ohms;
  logic signed [TEMP_W-1:0] out_temperature_centi_c;

  // predictor copy of the configuration
  longint unsigned fs_count, ref_ohms, nom_ohms, beta_k, t25_ck;

  reading_t pending_readings[$];
  row_t     rows[$];
  int       mismatches = 0;
  int       cycles = 0;
  bit       no_gaps = 0;

  ntc_beta_temperature_converter_core #(.ADC_BITS(ADC_W)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_adc_sample(in_adc_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_resistance_ohms(out_resistance_ohms),
    .out_temperature_centi_c(out_temperature_centi_c)
  );

  always #5 clk = ~clk;

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("ntc_beta_temperature_converter_core verification failed");
      $finish;
    end
  end

  // gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (no_gaps || p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // log2 in q28: mantissa normalised to q30, fraction by repeated squaring
  function automatic longint unsigned log2_fix(longint unsigned x);
    int unsigned e = 0;
    longint unsigned m;
    longint unsigned frac = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    for (int i = 0; i < 28; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (longint'(e) << 28) | frac;
  endfunction

  // expected reading for one adc count under the current configuration
  function automatic reading_t convert_count(logic [ADC_W-1:0] sample);
    reading_t r;
    longint unsigned cnt, den, num, q, lnum, lden, mag, lmag, numer, tck;
    longint lq, d;
    bit neg;
    cnt = sample;
    if (cnt >= fs_count) begin
      r.st = ST_FULL_SCALE; r.ohms = '1; r.temp = TEMP_ABS_ZERO;
      return r;
    end
    if (cnt == 0) begin
      r.st = ST_ZERO; r.ohms = '0; r.temp = TEMP_ABS_ZERO;
      return r;
    end
    den = fs_count - cnt;
    num = ref_ohms * cnt;
    q = (2 * num + den) / (2 * den);
    r.ohms = (q > 64'hFFFF_FFFF) ? '1 : q[RES_W-1:0];
    if (nom_ohms == 0 || beta_k == 0 || ref_ohms == 0 || t25_ck == 0) begin
      r.st = ST_BAD_CFG; r.temp = '0;
      return r;
    end
    lnum = log2_fix(num);
    lden = log2_fix(nom_ohms * den);
    neg = lden > lnum;
    mag = neg ? lden - lnum : lnum - lden;
    lmag = (mag * LN2_FIX + (64'd1 << 31)) >> 32;
    lq = neg ? -longint'(lmag) : longint'(lmag);
    d = longint'((100 * beta_k) << 24) + lq * longint'(t25_ck);
    if (d <= 0) begin
      r.st = ST_TEMP_SAT; r.temp = TEMP_MAX;
      return r;
    end
    numer = (100 * beta_k * t25_ck) << 24;
    tck = (numer + longint'(unsigned'(d)) / 2) / longint'(unsigned'(d));
    if (tck > 32767 + ZERO_C) begin
      r.st = ST_TEMP_SAT; r.temp = TEMP_MAX;
      return r;
    end
    r.st = ST_OK;
    r.temp = 16'(longint'(tck) - ZERO_C);
    return r;
  endfunction

  // result side: random back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(7) == 0) stall_left = gap_len();
      end
    end
  end

  // compare each delivered item with the oldest pending reading
  always @(posedge clk) begin
    reading_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: status %0d", out_status);
      end else begin
        w = pending_readings.pop_front();
        if (out_status !== w.st || out_resistance_ohms !== w.ohms ||
            out_temperature_centi_c !== w.temp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d ohms %0d temp %0d, got st %0d ohms %0d temp %0d",
                     w.st, w.ohms, $signed(w.temp), out_status,
                     out_resistance_ohms, out_temperature_centi_c);
        end
      end
    end
  end

  task automatic send_sample(logic [ADC_W-1:0] s, bit typed, reading_t answer);
    int n;
    @(negedge clk);
    in_valid <= 1'b1;
    in_adc_sample <= s;
    do @(posedge clk); while (!in_ready);
    pending_readings.push_back(typed ? answer : convert_count(s));
    n = gap_len();
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // hold the input until every pending item is out, then let the pipe empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // one register write; caller has drained the block
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_DATA_W-1:0];
    case (idx)
      REG_FULL_SCALE: fs_count = v & ((64'd1 << ADC_W) - 1);
      REG_REF_OHMS:   ref_ohms = v & 64'hFF_FFFF;
      REG_NOM_OHMS:   nom_ohms = v & 64'hFF_FFFF;
      REG_BETA:       beta_k   = v & 64'hFFFF;
      REG_NOM_CK:     t25_ck   = v & 64'hFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_write(cfg_reg_t idx, longint unsigned v);
    row_t r;
    r = '{kind: ROW_WRITE, idx: idx, value: v[CFG_DATA_W-1:0], sample: '0,
          typed: 0, answer: '{ST_OK, '0, '0}};
    rows.push_back(r);
  endfunction

  function automatic void add_sample(int s, bit typed = 0, status_t st = ST_OK,
                                     longint unsigned ohms = 0, int temp = 0);
    row_t r;
    r = '{kind: ROW_SAMPLE, idx: '0, value: '0, sample: s[ADC_W-1:0], typed: typed,
          answer: '{st, ohms[RES_W-1:0], temp[TEMP_W-1:0]}};
    rows.push_back(r);
  endfunction

  function automatic logic [ADC_W-1:0] pick_sample();
    int p;
    p = $urandom_range(99);
    if (p < 5) return '0;
    if (p < 10) return ADC_W'($urandom_range((1 << ADC_W) - 1, fs_count));
    if (p < 20 || fs_count < 2) return ADC_W'($urandom);
    return ADC_W'($urandom_range(fs_count - 1, 1));
  endfunction

  function automatic longint unsigned pick_reg(cfg_reg_t idx);
    int p;
    p = $urandom_range(99);
    case (idx)
      REG_FULL_SCALE:
        return (p < 20) ? 4095 : (p < 25) ? 1 : (p < 35) ? 255 : $urandom_range(4095, 64);
      REG_REF_OHMS, REG_NOM_OHMS: begin
        if (idx == REG_NOM_OHMS && p < 4) return 0;
        if (p < 10) return 24'hFF_FFFF;
        if (p < 15) return 1;
        return $urandom_range(200000, 100);
      end
      REG_BETA:
        return (p < 4) ? 0 : (p < 10) ? 16'hFFFF : (p < 15) ? 1 : $urandom_range(5000, 2000);
      default:
        return (p < 8) ? 16'hFFFF : (p < 14) ? 1 : $urandom_range(40000, 20000);
    endcase
  endfunction

  initial begin
    reading_t none;
    int per_phase;
    none = '{ST_OK, '0, '0};

    fs_count = FS_RST;
    ref_ohms = REF_RST;
    nom_ohms = NOM_RST;
    beta_k   = BETA_RST;
    t25_ck   = T25_RST;

    // defaults: both rails, midscale, one off each rail
    add_sample(0, 1, ST_ZERO, 0, -27315);
    add_sample(4095, 1, ST_FULL_SCALE, 64'hFFFF_FFFF, -27315);
    add_sample(2048);
    add_sample(1);
    add_sample(4094);
    // reduced full scale: counts at and above it saturate
    add_write(REG_FULL_SCALE, 1000);
    add_sample(1000, 1, ST_FULL_SCALE, 64'hFFFF_FFFF, -27315);
    add_sample(3000, 1, ST_FULL_SCALE, 64'hFFFF_FFFF, -27315);
    add_sample(999);
    // full scale of zero: every count reads as at full scale
    add_write(REG_FULL_SCALE, 0);
    add_sample(0, 1, ST_FULL_SCALE, 64'hFFFF_FFFF, -27315);
    add_write(REG_FULL_SCALE, 4095);
    // zero nominal resistance, then zero beta: bad configuration
    add_write(REG_NOM_OHMS, 0);
    add_sample(500);
    add_write(REG_NOM_OHMS, 10000);
    add_write(REG_BETA, 0);
    add_sample(2000);
    // widest reference: resistance saturates near full scale
    add_write(REG_BETA, 65535);
    add_write(REG_REF_OHMS, 24'hFF_FFFF);
    add_sample(4094);
    add_sample(2047);
    // tiny ratio with weak beta drives the denominator negative
    add_write(REG_REF_OHMS, 1);
    add_write(REG_NOM_OHMS, 24'hFF_FFFF);
    add_write(REG_BETA, 1);
    add_write(REG_NOM_CK, 65535);
    add_sample(1);
    add_sample(4094);
    // zero nominal temperature, then an unused index that must be ignored
    add_write(REG_NOM_CK, 0);
    add_sample(100);
    add_write(cfg_reg_t'(3'd7), 24'h00_1234);
    add_write(REG_NOM_CK, 1);
    add_sample(4000);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        drain();
        write_reg(rows[i].idx, rows[i].value);
      end else begin
        send_sample(rows[i].sample, rows[i].typed, rows[i].answer);
      end
    end

    // random phases, each under a fresh configuration; the first keeps defaults
    per_phase = RAND_ITEMS / N_PHASES;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      if (ph == 0) begin
        write_reg(REG_FULL_SCALE, FS_RST);
        write_reg(REG_REF_OHMS, REF_RST);
        write_reg(REG_NOM_OHMS, NOM_RST);
        write_reg(REG_BETA, BETA_RST);
        write_reg(REG_NOM_CK, T25_RST);
      end else begin
        for (int k = REG_FULL_SCALE; k <= REG_NOM_CK; k++)
          write_reg(cfg_reg_t'(k), pick_reg(cfg_reg_t'(k)));
      end
      // some phases run back to back with no gaps on the input side
      no_gaps = ($urandom_range(3) == 0);
      repeat (per_phase) send_sample(pick_sample(), 0, none);
    end
    no_gaps = 0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && pending_readings.size() == 0)
      $display("ntc_beta_temperature_converter_core verification clean");
    else
      $display("ntc_beta_temperature_converter_core verification failed");
    $finish;
  end

endmodule
